[design/srd_pkg.sv]
// ----------------------------------------------------------------------------
// Sensor response deframer package
// Types, frame constants and the result record shared by the deframer files.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int WIN_LEN     = 14;
    localparam int FILL_W      = 4;

    localparam logic [FILL_W-1:0] FILL_RESP = FILL_W'(13);
    localparam logic [FILL_W-1:0] FILL_DATA = FILL_W'(14);

    localparam logic [7:0] HDR0       = 8'hDE;
    localparam logic [7:0] HDR1       = 8'hAD;
    localparam logic [7:0] TRL0       = 8'hBE;
    localparam logic [7:0] TRL1       = 8'hEF;
    localparam logic [7:0] CODE_CFG   = 8'h02;
    localparam logic [7:0] CODE_OTHER = 8'h03;

    typedef enum logic [2:0] {
        KIND_CFG     = 3'd0,
        KIND_OTHER   = 3'd1,
        KIND_RAW     = 3'd2,
        KIND_DATA    = 3'd3,
        KIND_UNKNOWN = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    typedef logic [7:0]             t_byte;
    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        t_kind       frame_kind;
        logic [7:0]  command_code;
        logic [31:0] stream_delay_ms;
        logic [31:0] samples_sent;
        logic [15:0] field_x;
        logic [15:0] field_y;
        logic [15:0] field_z;
        logic [31:0] kind_count;
        logic        last_result;
    } t_result;

endpackage

[design/srd_if.sv]
// ----------------------------------------------------------------------------
// Sensor response deframer channels
// Byte input channel and frame result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srd_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface srd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  frame_kind;
    logic [7:0]  command_code;
    logic [31:0] stream_delay_ms;
    logic [31:0] samples_sent;
    logic [15:0] field_x;
    logic [15:0] field_y;
    logic [15:0] field_z;
    logic [31:0] kind_count;
    logic        last_result;

    modport source (
        output valid, output frame_kind, output command_code, output stream_delay_ms,
        output samples_sent, output field_x, output field_y, output field_z,
        output kind_count, output last_result, input ready
    );
    modport sink (
        input valid, input frame_kind, input command_code, input stream_delay_ms,
        input samples_sent, input field_x, input field_y, input field_z,
        input kind_count, input last_result, output ready
    );
endinterface

[design/sensor_response_deframer.sv]
// A byte is taken in the idle state, then the scan makes one decision per leading
// byte dropped by the shared window shifter, plus a final one. An unknown frame is
// held while the search goes on and is sent before a response found after it.
// No new byte is taken until the scan and any result on the output are done.
// Results leave a held register; reset (sync, active low) empties window, counters.
// ----------------------------------------------------------------------------
// Sensor response deframer
// Byte window with header search, response/data frame decode and counters.
// ----------------------------------------------------------------------------
module sensor_response_deframer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srd_in_if.sink    i_in,
    srd_out_if.source o_out
);
    import srd_pkg::*;

    t_state                r_state, n_state;
    logic [FILL_W-1:0]     r_fill, n_fill;
    t_byte                 r_win [WIN_LEN];
    t_byte                 n_win [WIN_LEN];
    t_byte                 w_shift [WIN_LEN];
    t_count                r_cnt [5];
    t_count                n_cnt [5];
    t_result               r_out, n_out;
    logic                  r_pend, n_pend;

    logic                  hdr_bad, resp_hit, data_full, data_hit;
    t_kind                 resp_kind, sel_kind;
    t_count                cnt_inc;

    // shared one byte shifter: drop the front byte
    always_comb begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
            w_shift[i] = r_win[i+1];
        end
        w_shift[WIN_LEN-1] = r_win[WIN_LEN-1];
    end

    always_comb begin
        hdr_bad   = ((r_fill >= FILL_W'(1)) && (r_win[0] != HDR0)) ||
                    ((r_fill >= FILL_W'(2)) && (r_win[1] != HDR1));
        resp_hit  = (r_fill == FILL_RESP) && (r_win[11] == TRL0) && (r_win[12] == TRL1);
        data_full = (r_fill == FILL_DATA);
        data_hit  = data_full && (r_win[12] == TRL0) && (r_win[13] == TRL1);
        case (r_win[6])
            CODE_CFG:   resp_kind = KIND_CFG;
            CODE_OTHER: resp_kind = KIND_OTHER;
            default:    resp_kind = KIND_RAW;
        endcase
        if (resp_hit) begin
            sel_kind = resp_kind;
        end else if (data_hit) begin
            sel_kind = KIND_DATA;
        end else begin
            sel_kind = KIND_UNKNOWN;
        end
        // shared counter incrementer
        cnt_inc = r_cnt[sel_kind] + COUNT_WIDTH'(1);
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_win   = r_win;
        n_cnt   = r_cnt;
        n_out   = r_out;
        n_pend  = r_pend;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.mode) begin
                        for (int k = 0; k < 5; k++) begin
                            n_cnt[k] = '0;
                        end
                    end else begin
                        if (r_fill == FILL_DATA) begin
                            n_win            = w_shift;
                            n_win[WIN_LEN-1] = i_in.rx_byte;
                        end else begin
                            n_win[r_fill] = i_in.rx_byte;
                            n_fill        = r_fill + FILL_W'(1);
                        end
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hdr_bad) begin
                    n_win  = w_shift;
                    n_fill = r_fill - FILL_W'(1);
                end else if (resp_hit) begin
                    if (r_pend) begin
                        // send the held unknown first, then come back here
                        n_pend  = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_out                 = '0;
                        n_out.frame_kind      = resp_kind;
                        n_out.command_code    = r_win[6];
                        if (resp_kind == KIND_CFG) begin
                            n_out.stream_delay_ms = {r_win[7], r_win[8], r_win[9], r_win[10]};
                        end
                        n_out.kind_count      = 32'(cnt_inc);
                        n_out.last_result     = 1'b1;
                        n_cnt[sel_kind]       = cnt_inc;
                        n_fill                = '0;
                        n_state               = S_OUT;
                    end
                end else if (data_hit) begin
                    n_out              = '0;
                    n_out.frame_kind   = KIND_DATA;
                    n_out.samples_sent = {r_win[2], r_win[3], r_win[4], r_win[5]};
                    n_out.field_x      = {r_win[6], r_win[7]};
                    n_out.field_y      = {r_win[8], r_win[9]};
                    n_out.field_z      = {r_win[10], r_win[11]};
                    n_out.kind_count   = 32'(cnt_inc);
                    n_out.last_result  = 1'b1;
                    n_cnt[sel_kind]    = cnt_inc;
                    n_fill             = '0;
                    n_state            = S_OUT;
                end else if (data_full) begin
                    // unknown frame: hold the item, drop one byte and search on
                    n_out            = '0;
                    n_out.frame_kind = KIND_UNKNOWN;
                    n_out.kind_count = 32'(cnt_inc);
                    n_cnt[sel_kind]  = cnt_inc;
                    n_pend           = 1'b1;
                    n_win            = w_shift;
                    n_fill           = r_fill - FILL_W'(1);
                end else if (r_pend) begin
                    n_out.last_result = 1'b1;
                    n_pend            = 1'b0;
                    n_state           = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = r_out.last_result ? S_IDLE : S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            for (int k = 0; k < 5; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_out <= n_out;
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = (r_state == S_OUT);
    assign o_out.frame_kind      = r_out.frame_kind;
    assign o_out.command_code    = r_out.command_code;
    assign o_out.stream_delay_ms = r_out.stream_delay_ms;
    assign o_out.samples_sent    = r_out.samples_sent;
    assign o_out.field_x         = r_out.field_x;
    assign o_out.field_y         = r_out.field_y;
    assign o_out.field_z         = r_out.field_z;
    assign o_out.kind_count      = r_out.kind_count;
    assign o_out.last_result     = r_out.last_result;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_DATA)
        else $error("window fill beyond frame length");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input taken while a result is shown");

    a_frame_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (r_out.frame_kind != KIND_UNKNOWN)) |-> (r_fill == '0))
        else $error("window not emptied after a decoded frame");

    a_pend_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_fill <= FILL_RESP) && (r_state == S_SCAN))
        else $error("held unknown item outside the scan");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.mode) |=>
            ((r_cnt[0] == '0) && (r_cnt[1] == '0) && (r_cnt[2] == '0) &&
             (r_cnt[3] == '0) && (r_cnt[4] == '0)))
        else $error("counters not cleared by command");

endmodule

[dv/tb_sensor_response_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor response deframer testbench
// Feeds byte streams and clear commands through the input channel and checks
// every decoded frame result, field by field, against an in-bench deframer.
// ----------------------------------------------------------------------------
module tb_sensor_response_deframer;
    import srd_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEM_TARGET  = 700;

    typedef struct packed {
        logic  mode;
        t_byte rx_byte;
    } t_link_item;

    logic clk = 1'b0;
    logic rst_n;

    srd_in_if  byte_ch ();
    srd_out_if frame_ch ();

    sensor_response_deframer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (frame_ch)
    );

    always #2 clk = ~clk;

    t_link_item pending_items[$];
    t_result    frames_due[$];
    t_byte      frame_buf[$];

    // Deframer state mirrored in the bench
    t_byte  win [WIN_LEN];
    int     win_fill;
    t_count kind_tally [5];

    int   mismatches;
    logic byte_taken;
    int   burst_left;
    int   gap_left;
    int   rx_cycle;
    int   idle_cycles;

    // ------------------------------------------------------------------
    // Reference deframer
    // ------------------------------------------------------------------
    function automatic void shift_window();
        if (win_fill > 0) begin
            for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i + 1];
            win_fill--;
        end
    endfunction

    function automatic void deframe_item(input t_link_item it);
        t_result r;
        int      produced;
        bit      searching;
        produced  = 0;
        searching = 1'b1;
        if (it.mode) begin
            foreach (kind_tally[k]) kind_tally[k] = '0;
            return;
        end
        if (win_fill >= WIN_LEN) shift_window();
        win[win_fill] = it.rx_byte;
        win_fill++;
        while (searching && produced < 2) begin
            r = '0;
            if (win_fill >= 1 && win[0] != HDR0) begin
                shift_window();
            end else if (win_fill >= 2 && win[1] != HDR1) begin
                shift_window();
            end else if (win_fill == int'(FILL_RESP) && win[11] == TRL0 && win[12] == TRL1) begin
                r.command_code = win[6];
                if (win[6] == CODE_CFG) begin
                    r.frame_kind      = KIND_CFG;
                    r.stream_delay_ms = {win[7], win[8], win[9], win[10]};
                end else if (win[6] == CODE_OTHER) begin
                    r.frame_kind = KIND_OTHER;
                end else begin
                    r.frame_kind = KIND_RAW;
                end
                kind_tally[r.frame_kind] = kind_tally[r.frame_kind] + COUNT_WIDTH'(1);
                r.kind_count = kind_tally[r.frame_kind];
                frames_due.push_back(r);
                produced++;
                win_fill  = 0;
                searching = 1'b0;
            end else if (win_fill == int'(FILL_DATA)) begin
                if (win[12] == TRL0 && win[13] == TRL1) begin
                    r.frame_kind   = KIND_DATA;
                    r.samples_sent = {win[2], win[3], win[4], win[5]};
                    r.field_x      = {win[6], win[7]};
                    r.field_y      = {win[8], win[9]};
                    r.field_z      = {win[10], win[11]};
                    win_fill       = 0;
                    searching      = 1'b0;
                end else begin
                    // drop one byte and search again at once
                    r.frame_kind = KIND_UNKNOWN;
                    shift_window();
                end
                kind_tally[r.frame_kind] = kind_tally[r.frame_kind] + COUNT_WIDTH'(1);
                r.kind_count = kind_tally[r.frame_kind];
                frames_due.push_back(r);
                produced++;
            end else begin
                searching = 1'b0;
            end
        end
        if (produced > 0) frames_due[frames_due.size() - 1].last_result = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Sample both channels; predict on accepted items, check accepted results
    always @(posedge clk) begin
        t_result    want;
        t_link_item it;
        if (frame_ch.valid && frame_ch.ready && rst_n) begin
            if (frames_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result, kind %0d count %0d",
                                          frame_ch.frame_kind, frame_ch.kind_count));
            end else begin
                want = frames_due.pop_front();
                compare_field("frame_kind",      32'(frame_ch.frame_kind),
                              32'(want.frame_kind));
                compare_field("command_code",    32'(frame_ch.command_code),
                              32'(want.command_code));
                compare_field("stream_delay_ms", frame_ch.stream_delay_ms,
                              want.stream_delay_ms);
                compare_field("samples_sent",    frame_ch.samples_sent,    want.samples_sent);
                compare_field("field_x",         32'(frame_ch.field_x),    32'(want.field_x));
                compare_field("field_y",         32'(frame_ch.field_y),    32'(want.field_y));
                compare_field("field_z",         32'(frame_ch.field_z),    32'(want.field_z));
                compare_field("kind_count",      frame_ch.kind_count,      want.kind_count);
                compare_field("last_result",     32'(frame_ch.last_result),
                              32'(want.last_result));
            end
        end
        if (byte_ch.valid && byte_ch.ready && rst_n) begin
            it.mode    = byte_ch.mode;
            it.rx_byte = byte_ch.rx_byte;
            deframe_item(it);
            byte_taken <= 1'b1;
        end else begin
            byte_taken <= 1'b0;
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (frame_ch.valid && frame_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of items with random gaps
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        t_link_item it;
        if (rst_n && !(byte_ch.valid && !byte_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                byte_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                byte_ch.valid   <= 1'b1;
                byte_ch.mode    <= it.mode;
                byte_ch.rx_byte <= it.rx_byte;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 60);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall style steps through four patterns in turn
    always @(negedge clk) begin
        rx_cycle++;
        if (!rst_n) begin
            frame_ch.ready <= 1'b0;
        end else begin
            case ((rx_cycle / 300) % 4)
                0:       frame_ch.ready <= 1'b1;
                1:       frame_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       frame_ch.ready <= ($urandom_range(0, 3) == 0);
                default: frame_ch.ready <= ((rx_cycle % 9) < 4);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_byte(input t_byte b);
        pending_items.push_back('{1'b0, b});
    endtask

    task automatic queue_clear();
        pending_items.push_back('{1'b1, t_byte'($urandom)});
    endtask

    function automatic t_byte payload_byte(input int style);
        case (style)
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return t_byte'($urandom);
        endcase
    endfunction

    task automatic build_response(input t_byte code, input logic [31:0] delay);
        int style;
        style     = $urandom_range(0, 7);
        frame_buf = {HDR0, HDR1};
        repeat (4) frame_buf.push_back(payload_byte(style));
        frame_buf.push_back(code);
        for (int i = 3; i >= 0; i--) frame_buf.push_back(delay[i*8 +: 8]);
        frame_buf.push_back(TRL0);
        frame_buf.push_back(TRL1);
    endtask

    task automatic build_data();
        int style;
        style     = $urandom_range(0, 7);
        frame_buf = {HDR0, HDR1};
        repeat (10) frame_buf.push_back(payload_byte(style));
        frame_buf.push_back(TRL0);
        frame_buf.push_back(TRL1);
    endtask

    // Queue the first keep bytes of frame_buf, a clear command before index clear_at
    task automatic push_frame(input int keep, input int clear_at);
        for (int i = 0; i < keep; i++) begin
            if (i == clear_at) queue_clear();
            queue_byte(frame_buf[i]);
        end
    endtask

    function automatic logic [31:0] pick_delay();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        rst_n           = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.mode    = 1'b0;
        byte_ch.rx_byte = 8'h00;
        frame_ch.ready  = 1'b0;
        byte_taken      = 1'b0;
        burst_left      = $urandom_range(1, 60);
        gap_left        = 0;
        rx_cycle        = 0;
        idle_cycles     = 0;
        mismatches      = 0;
        win_fill        = 0;
        foreach (win[i]) win[i] = '0;
        foreach (kind_tally[k]) kind_tally[k] = '0;

        // Directed: clear with all ones, lone header byte, then a config echo
        pending_items.push_back('{1'b1, 8'hFF});
        queue_byte(HDR0);
        queue_byte(8'h00);
        frame_buf = {HDR0, HDR1, 8'h00, 8'h00, 8'h00, 8'h00, CODE_CFG,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, TRL0, TRL1};
        push_frame(13, -1);

        while (pending_items.size() < ITEM_TARGET) begin
            case ($urandom_range(0, 11))
                0, 1: begin
                    build_response(CODE_CFG, pick_delay());
                    push_frame(13, -1);
                end
                2: begin
                    build_response(CODE_OTHER, $urandom);
                    push_frame(13, -1);
                end
                3: begin
                    build_response(t_byte'($urandom), $urandom);
                    push_frame(13, -1);
                end
                4, 5: begin
                    build_data();
                    push_frame(14, -1);
                end
                6: begin
                    // header with random body, mostly an unknown frame
                    frame_buf = {HDR0, HDR1};
                    repeat (12) frame_buf.push_back(t_byte'($urandom));
                    push_frame(14, -1);
                end
                7: begin
                    repeat ($urandom_range(1, 6))
                        queue_byte(($urandom_range(0, 3) == 0) ? HDR0 : t_byte'($urandom));
                end
                8: begin
                    // broken frame, cut short
                    if ($urandom_range(0, 1)) build_data();
                    else build_response(t_byte'($urandom_range(1, 4)), $urandom);
                    push_frame($urandom_range(1, frame_buf.size() - 1), -1);
                end
                9: queue_clear();
                10: begin
                    // stray header byte just ahead of a frame
                    queue_byte(HDR0);
                    build_response(t_byte'($urandom_range(1, 4)), pick_delay());
                    push_frame(13, -1);
                end
                default: begin
                    build_data();
                    push_frame(14, $urandom_range(0, 13));
                end
            endcase
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(pending_items.size() == 0 && !byte_ch.valid && frames_due.size() == 0))
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sensor_response_deframer.f]
design/srd_pkg.sv
design/srd_if.sv
design/sensor_response_deframer.sv
dv/tb_sensor_response_deframer.sv
